@@ rtl/lru_key_value_cache_core_macros.svh @@
// Assertion macros for the key-value cache core.
// Depends on a module that has i_clk and a synchronous active-low i_rst_n.
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define LKV_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lkv_pkg.sv @@
// Shared types and constants for the key-value cache core.
// No dependencies; used by lkv_cell and lru_key_value_cache_core.
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 5;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic upd;
        logic all;
        logic evict;
    } t_cell_ctrl;

endpackage

@@ rtl/lkv_cell.sv @@
// One recency slot of the cache chain: holds an entry, compares its key,
// and takes its left neighbor's entry when the chain shifts. Uses lkv_pkg.
module lkv_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lkv_pkg::t_cell_ctrl       i_ctrl,
    input  logic [lkv_pkg::KEY_W-1:0] i_key,
    input  lkv_pkg::t_entry           i_left,
    input  logic                      i_sfx,
    input  logic [lkv_pkg::DATA_W-1:0] i_data_or,
    input  logic                      i_nv_right,
    output lkv_pkg::t_entry           o_entry,
    output logic                      o_sfx,
    output logic [lkv_pkg::DATA_W-1:0] o_data_or,
    output logic                      o_nv
);
    import lkv_pkg::*;

    logic              r_valid;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_data;
    logic              n_valid;
    logic [KEY_W-1:0]  n_key;
    logic [DATA_W-1:0] n_data;
    logic              w_match;
    logic              w_shift;
    logic              w_kill;

    always_comb begin
        w_match   = r_valid && (r_key == i_key);
        o_sfx     = w_match | i_sfx;
        o_data_or = i_data_or | (w_match ? r_data : '0);
        w_shift   = i_ctrl.upd && (i_ctrl.all || o_sfx);
        o_nv      = w_shift ? i_left.valid : r_valid;
        w_kill    = i_ctrl.evict && o_nv && !i_nv_right;
        n_valid   = o_nv && !w_kill;
        n_key     = w_shift ? i_left.key : r_key;
        n_data    = w_shift ? i_left.data : r_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key  <= n_key;
        r_data <= n_data;
    end

    assign o_entry = '{valid: r_valid, key: r_key, data: r_data};

endmodule

@@ rtl/lru_key_value_cache_core.sv @@
// Top level of the fully associative key-value cache with LRU replacement.
// Depends on lkv_pkg, lkv_cell and lru_key_value_cache_core_macros.svh.
//
// Usage:
// A command beat is taken at a rising edge where start is high and busy is
// low. i_command selects a lookup or a write of i_key with i_value.
// Entries live in a chain of cells ordered by recency, the most recent in
// the first cell. Every cell compares its key in the same cycle; on a hit
// the matching entry moves to the head and the cells in front of it shift
// back by one, and a write of a new key shifts the whole chain.
// The result beat is on o_hit, o_read_value and o_evicted for exactly one
// cycle with o_result_valid high, on the cycle after the command was taken.
// One command is taken per cycle while busy is low.
// The result cannot be held off; the receiver must take it when offered.
// The capacity register is written over i_cfg_data when i_cfg_valid and
// o_cfg_ready are high; the user must do so only while no command is in
// flight, which the block does not enforce. Reset empties the cache, sets
// capacity to 16 and holds busy high for one cycle after reset is released.
module lru_key_value_cache_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_command,
    input  logic signed [lkv_pkg::KEY_W-1:0]  i_key,
    input  logic signed [lkv_pkg::DATA_W-1:0] i_value,
    output logic                              o_result_valid,
    output logic                              o_hit,
    output logic signed [lkv_pkg::DATA_W-1:0] o_read_value,
    output logic                              o_evicted,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lkv_pkg::CFG_W-1:0]         i_cfg_data
);
    import lkv_pkg::*;

`include "lru_key_value_cache_core_macros.svh"

    logic              r_busy;
    logic [CFG_W-1:0]  r_cap;
    logic [OCC_W-1:0]  r_occ;
    logic              r_res_valid;
    logic              r_hit;
    logic [DATA_W-1:0] r_rd;
    logic              r_ev;

    logic [OCC_W-1:0]  n_occ;
    logic [DATA_W-1:0] n_rd;
    logic              n_ev;

    logic              w_accept;
    logic              w_hit;
    logic              w_miss_write;
    logic              w_full;
    logic              w_evict_extra;
    logic [OCC_W-1:0]  w_new_occ;
    logic [CMP_W-1:0]  w_eff_cap;
    t_cell_ctrl        w_ctrl;
    t_entry            w_head;
    logic [ENTRIES-1:0] w_vld;

    t_entry            w_ent  [ENTRIES];
    t_entry            w_left [ENTRIES];
    logic              w_sfx  [ENTRIES+1];
    logic [DATA_W-1:0] w_dor  [ENTRIES+1];
    logic              w_nv   [ENTRIES+1];

    assign w_sfx[ENTRIES] = 1'b0;
    assign w_dor[ENTRIES] = '0;
    assign w_nv[ENTRIES]  = 1'b0;
    assign w_left[0]      = w_head;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g > 0) begin : g_link
            assign w_left[g] = w_ent[g-1];
        end
        lkv_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_key      (i_key),
            .i_left     (w_left[g]),
            .i_sfx      (w_sfx[g+1]),
            .i_data_or  (w_dor[g+1]),
            .i_nv_right (w_nv[g+1]),
            .o_entry    (w_ent[g]),
            .o_sfx      (w_sfx[g]),
            .o_data_or  (w_dor[g]),
            .o_nv       (w_nv[g])
        );
        assign w_vld[g] = w_ent[g].valid;
    end

    always_comb begin
        w_accept     = start && !r_busy;
        w_hit        = w_sfx[0];
        w_miss_write = (i_command == CMD_WRITE) && !w_hit;
        w_full       = (r_occ == OCC_W'(ENTRIES));

        if (r_cap == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(ENTRIES)) begin
            w_eff_cap = CMP_W'(ENTRIES);
        end else begin
            w_eff_cap = CMP_W'(r_cap);
        end

        w_new_occ     = (w_miss_write && !w_full) ? r_occ + OCC_W'(1) : r_occ;
        w_evict_extra = (i_command == CMD_WRITE) && !(w_miss_write && w_full)
                        && (CMP_W'(w_new_occ) > w_eff_cap);

        w_ctrl.upd   = w_accept && (w_hit || (i_command == CMD_WRITE));
        w_ctrl.all   = w_miss_write;
        w_ctrl.evict = w_accept && w_evict_extra;

        w_head.valid = 1'b1;
        w_head.key   = i_key;
        w_head.data  = (i_command == CMD_WRITE) ? i_value : w_dor[0];

        n_occ = w_accept ? (w_new_occ - OCC_W'(w_evict_extra)) : r_occ;

        if (i_command == CMD_WRITE) begin
            n_rd = '0;
            n_ev = (w_miss_write && w_full) || w_evict_extra;
        end else begin
            n_rd = w_hit ? w_dor[0] : '1;
            n_ev = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_busy      <= 1'b0;
            r_occ       <= n_occ;
            r_res_valid <= w_accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
        if (w_accept) begin
            r_hit <= w_hit;
            r_rd  <= n_rd;
            r_ev  <= n_ev;
        end
    end

    assign busy           = r_busy;
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_res_valid;
    assign o_hit          = r_hit;
    assign o_read_value   = r_rd;
    assign o_evicted      = r_ev;

    `LKV_ASSERT_NEXT(a_result_follows, w_accept, r_res_valid, "missing result beat")
    `LKV_ASSERT_NEXT(a_no_spurious, !w_accept, !r_res_valid, "result beat without command")
    `LKV_ASSERT_ALWAYS(a_occ_count, $countones(w_vld) == 32'(r_occ), "occupancy mismatch")
    `LKV_ASSERT_ALWAYS(a_valid_prefix, ((w_vld + ENTRIES'(1)) & w_vld) == '0, "hole in cell chain")

endmodule
